// ===== sv/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared shorthand for the concurrent checks of the queue design.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

// ===== sv/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes and the memory control group shared by the queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } spq_op_type;

   // Enables of the entry store, one write port and one read port.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } spq_mem_ctl_type;

endpackage
`default_nettype wire

// ===== sv/spq_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// Simple dual-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module spq_store
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48
) (
   input  wire logic                       clock,
   input  wire spq_mem_ctl_type            mem_ctl,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Stable minimum priority queue kept in sorted order in a circular memory.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Handshake
//   -------   ---------------------------   ----------------------------------
//   request   req_operation, req_item_*     taken when start is high, busy low
//   response  rsp_*                         rsp_valid strobe for one cycle
//
// Every transaction produces exactly one response. The entries live in one memory used as a
// ring whose head pointer marks logical slot zero. A dequeue that leaves entries advances the
// pointer and reads the new head in ST_DEQ_LOAD. An enqueue scans from the tail in ST_ENQ_SCAN,
// moving each larger entry up one slot. A dropped enqueue, an empty dequeue, a dequeue of the
// last entry or an insert into an empty queue go straight from ST_IDLE to ST_FINISH. Reset
// clears count, pointer and control state; the receiver cannot stall.
//
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY       = 16,
   parameter int VALUE_WIDTH    = 32,
   parameter int PRIORITY_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_operation,
   input  wire logic [VALUE_WIDTH-1:0]              req_item_value,
   input  wire logic [PRIORITY_WIDTH-1:0]           req_item_priority,
   output logic                                     rsp_valid,
   output logic      [VALUE_WIDTH-1:0]              rsp_head_value,
   output logic      [PRIORITY_WIDTH-1:0]           rsp_head_priority,
   output logic      [$clog2(CAPACITY+1)-1:0]       rsp_entry_count,
   output logic                                     rsp_queue_empty,
   output logic                                     rsp_overflow
);

`include "sorted_priority_queue_defines.svh"

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W = VALUE_WIDTH + PRIORITY_WIDTH;

   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
   localparam logic [ADDR_W:0]   RING_SIZE = (ADDR_W + 1)'(CAPACITY);
   localparam logic [ADDR_W-1:0] OFF_ONE   = ADDR_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_SCAN,
      ST_ENQ_HEAD,
      ST_DEQ_LOAD,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [ADDR_W-1:0]         head_ptr_ff;
   logic [ADDR_W-1:0]         scan_ff;
   logic [VALUE_WIDTH-1:0]    new_value_ff;
   logic [PRIORITY_WIDTH-1:0] new_priority_ff;
   logic [VALUE_WIDTH-1:0]    head_value_ff;
   logic [PRIORITY_WIDTH-1:0] head_priority_ff;
   logic                      overflow_ff;

   logic                      rsp_valid_ff;
   logic [VALUE_WIDTH-1:0]    rsp_head_value_ff;
   logic [PRIORITY_WIDTH-1:0] rsp_head_priority_ff;
   logic [CNT_W-1:0]          rsp_entry_count_ff;
   logic                      rsp_queue_empty_ff;
   logic                      rsp_overflow_ff;

   spq_mem_ctl_type           mem_ctl;
   logic [ADDR_W-1:0]         wr_addr;
   logic [WORD_W-1:0]         wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [WORD_W-1:0]         rd_data;
   logic [VALUE_WIDTH-1:0]    rd_value;
   logic [PRIORITY_WIDTH-1:0] rd_priority;
   logic                      accept;
   logic                      moves_up;
   logic [ADDR_W-1:0]         tail_off;

   // Map a logical slot, counted from the head, to a memory address.
   function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= RING_SIZE) begin
         sum = sum - RING_SIZE;
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign rd_priority = rd_data[PRIORITY_WIDTH-1:0];
   assign rd_value    = rd_data[PRIORITY_WIDTH +: VALUE_WIDTH];
   // Strictly larger priorities move up, so equal priorities keep arrival order.
   assign moves_up    = (rd_priority > new_priority_ff);
   // Last occupied logical slot; only used while the queue is neither empty nor full.
   assign tail_off    = ADDR_W'(count_ff - CNT_ONE);

   // Memory port control.
   always_comb begin
      mem_ctl = '0;
      wr_addr = head_ptr_ff;
      wr_data = {new_value_ff, new_priority_ff};
      rd_addr = head_ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_ENQUEUE) begin
                  if (count_ff == '0) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = {req_item_value, req_item_priority};
                  end else if (count_ff != CNT_FULL) begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = ring_addr(head_ptr_ff, tail_off);
                  end
               end else if (count_ff > CNT_ONE) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = ring_addr(head_ptr_ff, OFF_ONE);
               end
            end
         end
         ST_ENQ_SCAN: begin
            // The entry read last cycle either moves up one slot or the new
            // entry settles just above it.
            mem_ctl.wr_en = 1'b1;
            wr_addr       = ring_addr(head_ptr_ff, scan_ff + OFF_ONE);
            if (moves_up) begin
               wr_data = rd_data;
               if (scan_ff != '0) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = ring_addr(head_ptr_ff, scan_ff - OFF_ONE);
               end
            end
         end
         ST_ENQ_HEAD: begin
            mem_ctl.wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer, queue state and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  new_value_ff    <= req_item_value;
                  new_priority_ff <= req_item_priority;
                  overflow_ff     <= 1'b0;
                  state_ff        <= ST_FINISH;
                  if (req_operation == OP_ENQUEUE) begin
                     if (count_ff == CNT_FULL) begin
                        overflow_ff <= 1'b1;
                     end else if (count_ff == '0) begin
                        head_value_ff    <= req_item_value;
                        head_priority_ff <= req_item_priority;
                        count_ff         <= CNT_ONE;
                     end else begin
                        scan_ff  <= tail_off;
                        state_ff <= ST_ENQ_SCAN;
                     end
                  end else if (count_ff > CNT_ONE) begin
                     head_ptr_ff <= ring_addr(head_ptr_ff, OFF_ONE);
                     count_ff    <= count_ff - CNT_ONE;
                     state_ff    <= ST_DEQ_LOAD;
                  end else if (count_ff == CNT_ONE) begin
                     head_ptr_ff <= ring_addr(head_ptr_ff, OFF_ONE);
                     count_ff    <= '0;
                  end
               end
            end
            ST_ENQ_SCAN: begin
               if (moves_up) begin
                  if (scan_ff == '0) begin
                     state_ff <= ST_ENQ_HEAD;
                  end else begin
                     scan_ff <= scan_ff - OFF_ONE;
                  end
               end else begin
                  count_ff <= count_ff + CNT_ONE;
                  state_ff <= ST_FINISH;
               end
            end
            ST_ENQ_HEAD: begin
               head_value_ff    <= new_value_ff;
               head_priority_ff <= new_priority_ff;
               count_ff         <= count_ff + CNT_ONE;
               state_ff         <= ST_FINISH;
            end
            ST_DEQ_LOAD: begin
               head_value_ff    <= rd_value;
               head_priority_ff <= rd_priority;
               state_ff         <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_valid_ff       <= 1'b1;
               rsp_entry_count_ff <= count_ff;
               rsp_queue_empty_ff <= (count_ff == '0);
               rsp_overflow_ff    <= overflow_ff;
               if (count_ff == '0) begin
                  rsp_head_value_ff    <= '0;
                  rsp_head_priority_ff <= '0;
               end else begin
                  rsp_head_value_ff    <= head_value_ff;
                  rsp_head_priority_ff <= head_priority_ff;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   spq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = rsp_head_value_ff;
   assign rsp_head_priority = rsp_head_priority_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_queue_empty   = rsp_queue_empty_ff;
   assign rsp_overflow      = rsp_overflow_ff;

   // The count never exceeds the ring size.
   `SPQ_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_FULL)
   // A response strobe follows the finishing state and nothing else.
   `SPQ_ASSERT_SAME(a_rsp_after_finish, clock, reset, rsp_valid_ff, $past(state_ff == ST_FINISH))
   // A dropped enqueue is reported only against a full queue.
   `SPQ_ASSERT_SAME(a_overflow_full, clock, reset, rsp_valid_ff && rsp_overflow_ff,
                    rsp_entry_count_ff == CNT_FULL)
   // With no transaction in flight the memory is never written.
   `SPQ_ASSERT_SAME(a_idle_no_write, clock, reset, !busy && !start, !mem_ctl.wr_en)

endmodule
`default_nettype wire
